/* rtl/core/sha1_pkg.sv */
// sha1_pkg: constants, round helpers and sequencer state type for the sha-1 core
// no dependencies; imported by sha1_message_digest_core
package sha1_pkg;

	// initial chaining values h0..h4
	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	// round constants, one per group of twenty rounds
	localparam logic [31:0] K_ROUND [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	// padding marker byte and the word that carries it alone
	localparam logic [7:0]  PAD_BYTE  = 8'h80;
	localparam logic [31:0] PAD_WORD  = {PAD_BYTE, 24'h0};

	localparam int unsigned ROUNDS     = 80;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned DIGEST_WORDS = 5;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [3:0] LEN_HI_SLOT = 4'(BLOCK_WORDS - 2);
	localparam logic [3:0] LEN_LO_SLOT = 4'(BLOCK_WORDS - 1);
	localparam logic [2:0] LAST_INDEX  = 3'(DIGEST_WORDS - 1);
	localparam logic [2:0] FULL_BYTES  = 3'd4;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAD   = 5'b00010,
		S_ROUND = 5'b00100,
		S_ADD   = 5'b01000,
		S_OUT   = 5'b10000
	} seq_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	// round group 0..3 from round number
	function automatic logic [1:0] round_group(input logic [6:0] r);
		if (r < 7'd20)
			round_group = 2'd0;
		else if (r < 7'd40)
			round_group = 2'd1;
		else if (r < 7'd60)
			round_group = 2'd2;
		else
			round_group = 2'd3;
	endfunction

	// boolean function of the round group
	function automatic logic [31:0] round_f(input logic [1:0] g, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		case (g)
			2'd0:    round_f = d ^ (b & (c ^ d));
			2'd2:    round_f = (b & c) | (d & (b | c));
			default: round_f = b ^ c ^ d;
		endcase
	endfunction

endpackage

/* rtl/core/sha1_message_digest_core.sv */
// sha1_message_digest_core: sha-1 digest of a stream of big-endian 32-bit words
// depends on sha1_pkg (constants, round helpers, state type)
// a word that does not close a block is only stored; the sixteenth word of a
//   block starts a compression (load, 80 rounds on the shared round unit, chain add)
// msg_ready is low outside idle, so no word is taken while a block is being compressed
// final request: pad words one per cycle, one or two compressions, then 5 digest words
// reset: chaining values to the initial constants, fill and bit count cleared
module sha1_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  bytes_valid,
	input  logic        end_of_message,
	output logic        dig_valid,
	input  logic        dig_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1_pkg::*;

	seq_state_t  state_q;
	logic [3:0]  fill_q;
	logic [63:0] bit_count_q;
	logic [6:0]  round_q;
	logic [2:0]  idx_q;
	logic        fin_q;
	logic        mark_q;
	logic        len_hi_q;
	logic        len_lo_q;

	logic [31:0] w_q [BLOCK_WORDS];
	logic [31:0] h_q [DIGEST_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	logic        in_acc;
	logic        out_acc;
	logic [2:0]  n_eff;
	logic [31:0] padded_word;
	logic        push_en;
	logic [31:0] push_word;
	logic        block_full;
	logic [31:0] sched_word;
	logic [1:0]  grp;
	logic [31:0] t_word;

	assign in_acc  = msg_valid && msg_ready;
	assign out_acc = dig_valid && dig_ready;

	// oversized byte counts count as a full word
	assign n_eff = (bytes_valid > FULL_BYTES) ? FULL_BYTES : bytes_valid;

	// final partial word with the marker byte right after its data
	always_comb begin
		case (n_eff)
			3'd0:    padded_word = PAD_WORD;
			3'd1:    padded_word = {data_word[31:24], PAD_BYTE, 16'h0};
			3'd2:    padded_word = {data_word[31:16], PAD_BYTE, 8'h0};
			3'd3:    padded_word = {data_word[31:8], PAD_BYTE};
			default: padded_word = data_word;
		endcase
	end

	// word entering the block buffer
	always_comb begin
		push_en   = 1'b0;
		push_word = data_word;
		case (state_q)
			S_IDLE: begin
				push_en   = in_acc && (end_of_message || (n_eff != 3'd0));
				push_word = (end_of_message && (n_eff != FULL_BYTES)) ? padded_word : data_word;
			end
			S_PAD: begin
				push_en = 1'b1;
				if (mark_q)
					push_word = PAD_WORD;
				else if ((fill_q == LEN_HI_SLOT) && !len_hi_q)
					push_word = bit_count_q[63:32];
				else if ((fill_q == LEN_LO_SLOT) && len_hi_q)
					push_word = bit_count_q[31:0];
				else
					push_word = '0;
			end
			default: begin
				push_en   = 1'b0;
				push_word = data_word;
			end
		endcase
	end

	assign block_full = push_en && (fill_q == LEN_LO_SLOT);

	// shared round unit: schedule word and new a
	assign sched_word = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	assign grp        = round_group(round_q);
	assign t_word     = rotl(a_q, 5) + round_f(grp, b_q, c_q, d_q) + e_q + w_q[0]
		+ K_ROUND[grp];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			bit_count_q <= '0;
			round_q     <= '0;
			idx_q       <= '0;
			fin_q       <= 1'b0;
			mark_q      <= 1'b0;
			len_hi_q    <= 1'b0;
			len_lo_q    <= 1'b0;
		end else begin
			if (push_en)
				fill_q <= fill_q + 4'd1;
			if (block_full)
				round_q <= '0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (end_of_message) begin
							fin_q       <= 1'b1;
							mark_q      <= (n_eff == FULL_BYTES);
							bit_count_q <= bit_count_q + {58'h0, n_eff, 3'b000};
							state_q     <= block_full ? S_ROUND : S_PAD;
						end else if (n_eff != 3'd0) begin
							bit_count_q <= bit_count_q + 64'd32;
							if (block_full)
								state_q <= S_ROUND;
						end
					end
				end
				S_PAD: begin
					if (mark_q)
						mark_q <= 1'b0;
					else if ((fill_q == LEN_HI_SLOT) && !len_hi_q)
						len_hi_q <= 1'b1;
					else if ((fill_q == LEN_LO_SLOT) && len_hi_q)
						len_lo_q <= 1'b1;
					if (block_full)
						state_q <= S_ROUND;
				end
				S_ROUND: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND)
						state_q <= S_ADD;
				end
				S_ADD: begin
					idx_q <= '0;
					if (len_lo_q)
						state_q <= S_OUT;
					else if (fin_q)
						state_q <= S_PAD;
					else
						state_q <= S_IDLE;
				end
				S_OUT: begin
					if (dig_ready) begin
						if (idx_q == LAST_INDEX) begin
							state_q     <= S_IDLE;
							fin_q       <= 1'b0;
							len_hi_q    <= 1'b0;
							len_lo_q    <= 1'b0;
							bit_count_q <= '0;
							fill_q      <= '0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// block buffer as a 16-word window, shifted by fills and by schedule rounds
	always_ff @(posedge clk) begin
		if (push_en || (state_q == S_ROUND)) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				w_q[i] <= w_q[i + 1];
			w_q[BLOCK_WORDS - 1] <= push_en ? push_word : sched_word;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (block_full) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == S_ROUND) begin
			a_q <= t_word;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// chaining values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGEST_WORDS; i++)
				h_q[i] <= H_INIT[i];
		end else if (state_q == S_ADD) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end else if (out_acc && (idx_q == LAST_INDEX)) begin
			for (int i = 0; i < DIGEST_WORDS; i++)
				h_q[i] <= H_INIT[i];
		end
	end

	// handshake and digest output
	assign msg_ready   = (state_q == S_IDLE);
	assign dig_valid   = (state_q == S_OUT);
	assign digest_word = (idx_q > LAST_INDEX) ? h_q[0] : h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == LAST_INDEX);

	// input and output sides never open together
	assert property (@(posedge clk) disable iff (!arst_n) !(msg_ready && dig_valid))
		else $error("input ready while digest pending");

	// every compression starts from an empty buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ROUND) && (round_q == '0)) |-> (fill_q == '0))
		else $error("compression started with partial fill");

	// round counter stays inside the round range
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND) |-> (round_q <= LAST_ROUND))
		else $error("round counter out of range");

	// after the last digest word the block is clean and idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> ((state_q == S_IDLE) && (bit_count_q == '0)
		&& (fill_q == '0) && !fin_q))
		else $error("state not cleared after digest");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for sha1_message_digest_core, random message streams vs a sha-1 predictor
// depends on sha1_message_digest_core only; valid/ready on both sides with random stalls
module tb_top;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;
	localparam logic [31:0] KR0 = 32'h5a827999;
	localparam logic [31:0] KR1 = 32'h6ed9eba1;
	localparam logic [31:0] KR2 = 32'h8f1bbcdc;
	localparam logic [31:0] KR3 = 32'hca62c1d6;
	localparam logic [7:0]  MARK_BYTE = 8'h80;
	localparam logic [2:0]  WORD_BYTES = 3'd4;
	localparam logic [2:0]  TOP_INDEX = 3'd4;
	localparam int          TARGET_REQS = 270;
	localparam int          TAIL_CYCLES = 200;
	localparam int          MAX_PRINTS = 40;

	typedef struct {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        eom;
		bit          hold;
	} msg_req_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  bytes_valid = '0;
	logic        end_of_message = 1'b0;
	logic        dig_valid;
	logic        dig_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha1_message_digest_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.msg_ready     (msg_ready),
		.data_word     (data_word),
		.bytes_valid   (bytes_valid),
		.end_of_message(end_of_message),
		.dig_valid     (dig_valid),
		.dig_ready     (dig_ready),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word)
	);

	always #4 clk = ~clk;

	// predictor state: chaining value, block buffer, fill and bit count
	logic [31:0] chain_h [5];
	logic [31:0] blk_w [16];
	int unsigned fill_bytes;
	logic [63:0] bit_count;

	digest_exp_t expected_digest [$];
	msg_req_t    req_queue [$];
	msg_req_t    next_req;
	digest_exp_t want;

	int n_real_reqs = 0;
	int n_issued = 0;
	int n_taken = 0;
	int n_errors = 0;
	int send_gap = 0;
	int send_calm = 0;
	int recv_stall = 0;
	int recv_calm = 0;

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// mostly short gaps, a few long ones, and runs with none
	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic reset_chain();
		chain_h[0] = IV0;
		chain_h[1] = IV1;
		chain_h[2] = IV2;
		chain_h[3] = IV3;
		chain_h[4] = IV4;
		fill_bytes = 0;
		bit_count = '0;
	endtask

	// 80 rounds over the block buffer, folded into the chaining value
	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t;
		int r, s;
		w = blk_w;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (r = 0; r < 80; r++) begin
			s = r % 16;
			if (r >= 16)
				w[s] = rol(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
			if (r < 20) begin
				f = d ^ (b & (c ^ d));
				k = KR0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = KR1;
			end else if (r < 60) begin
				f = (b & c) | (d & (b | c));
				k = KR2;
			end else begin
				f = b ^ c ^ d;
				k = KR3;
			end
			t = rol(a, 5) + f + e + w[s] + k;
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic absorb_byte(input logic [7:0] v);
		int idx, sh;
		idx = fill_bytes / 4;
		sh = 24 - 8 * (fill_bytes % 4);
		if (fill_bytes % 4 == 0)
			blk_w[idx] = {24'h0, v} << sh;
		else
			blk_w[idx] = (blk_w[idx] & ~(32'hff << sh)) | ({24'h0, v} << sh);
		fill_bytes++;
		if (fill_bytes >= 64) begin
			compress_block();
			fill_bytes = 0;
		end
	endtask

	// apply one accepted request; a final request queues the five digest words
	task automatic sha1_absorb_request(input logic [31:0] data, input logic [2:0] nbytes,
			input logic eom);
		int n, i;
		logic [63:0] len;
		n = (nbytes > WORD_BYTES) ? 4 : int'(nbytes);
		if (!eom) begin
			if (n != 0)
				for (i = 0; i < 4; i++) begin
					absorb_byte(data[31 - 8 * i -: 8]);
					bit_count += 64'd8;
				end
			return;
		end
		for (i = 0; i < n; i++) begin
			absorb_byte(data[31 - 8 * i -: 8]);
			bit_count += 64'd8;
		end
		len = bit_count;
		absorb_byte(MARK_BYTE);
		while (fill_bytes != 56)
			absorb_byte(8'h00);
		for (i = 0; i < 8; i++)
			absorb_byte(len[63 - 8 * i -: 8]);
		for (i = 0; i < 5; i++)
			expected_digest.push_back('{word: chain_h[i], index: 3'(i),
				last: (3'(i) == TOP_INDEX)});
		reset_chain();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (n_errors < MAX_PRINTS)
			$display("mismatch at %0t: %s got %h exp %h", $time, what, got, exp_val);
		n_errors++;
	endtask

	task automatic queue_req(input logic [31:0] data, input logic [2:0] nbytes,
			input logic eom, input bit hold);
		req_queue.push_back('{data: data, nbytes: nbytes, eom: eom, hold: hold});
		if (eom || nbytes != 3'd0)
			n_real_reqs++;
	endtask

	// one message of random words; ignored requests sprinkled in as noise
	task automatic queue_message(input int n_words, input logic [2:0] tail_bytes,
			input bit hold_first);
		int i;
		bit hold;
		logic [2:0] nb;
		hold = hold_first;
		for (i = 0; i < n_words; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				queue_req($urandom, 3'd0, 1'b0, hold);
				hold = 0;
			end
			nb = ($urandom_range(0, 9) < 7) ? WORD_BYTES : 3'($urandom_range(1, 7));
			queue_req($urandom, nb, 1'b0, hold);
			hold = 0;
		end
		queue_req($urandom, tail_bytes, 1'b1, hold);
	endtask

	// request driver, updates on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			msg_valid <= 1'b0;
		end else if (n_taken == n_issued) begin
			if (send_gap > 0) begin
				send_gap--;
				msg_valid <= 1'b0;
			end else if (req_queue.size() > 0 &&
					!(req_queue[0].hold && expected_digest.size() != 0)) begin
				next_req = req_queue.pop_front();
				data_word <= next_req.data;
				bytes_valid <= next_req.nbytes;
				end_of_message <= next_req.eom;
				msg_valid <= 1'b1;
				n_issued++;
				send_gap = next_gap(send_calm);
			end else begin
				msg_valid <= 1'b0;
			end
		end
	end

	// digest side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			dig_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			dig_ready <= 1'b0;
		end else begin
			dig_ready <= 1'b1;
			recv_stall = next_gap(recv_calm);
		end
	end

	// accepted requests feed the predictor, accepted digest words are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg_valid && msg_ready) begin
				sha1_absorb_request(data_word, bytes_valid, end_of_message);
				n_taken++;
			end
			if (dig_valid && dig_ready) begin
				if (expected_digest.size() == 0) begin
					report_mismatch("digest word with none pending", digest_word, '0);
				end else begin
					want = expected_digest.pop_front();
					if (digest_word !== want.word)
						report_mismatch("digest_word", digest_word, want.word);
					if (word_index !== want.index)
						report_mismatch("word_index", {29'h0, word_index}, {29'h0, want.index});
					if (last_word !== want.last)
						report_mismatch("last_word", {31'h0, last_word}, {31'h0, want.last});
				end
			end
		end
	end

	// watchdog
	initial begin
		#8000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int len, r;
		bit first_hold;
		reset_chain();
		blk_w = '{default: '0};

		// directed: empty, short tails, oversized and partial counts, two-block padding
		queue_req(32'h00000000, 3'd0, 1'b1, 1'b0);
		queue_req(32'h61626300, 3'd3, 1'b1, 1'b0);
		queue_req(32'hffffffff, 3'd1, 1'b1, 1'b0);
		queue_req(32'h00000000, 3'd2, 1'b0, 1'b0);
		queue_req(32'hdeadbeef, 3'd0, 1'b0, 1'b0);
		queue_req(32'hffffffff, 3'd7, 1'b0, 1'b0);
		queue_req(32'h12345678, 3'd0, 1'b1, 1'b0);
		queue_req(32'h80000001, 3'd6, 1'b0, 1'b0);
		queue_req(32'ha5a5a5a5, 3'd5, 1'b1, 1'b0);
		queue_message(13, WORD_BYTES, 1'b0);

		// random messages, mostly short, some across block boundaries
		first_hold = 1;
		while (n_real_reqs < TARGET_REQS) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				len = $urandom_range(0, 8);
			else if (r < 9)
				len = $urandom_range(9, 17);
			else
				len = $urandom_range(18, 40);
			queue_message(len, 3'($urandom_range(0, 7)),
				first_hold || $urandom_range(0, 29) == 0);
			first_hold = 0;
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// drain everything, then let the core settle
		while (req_queue.size() != 0 || n_taken != n_issued)
			@(posedge clk);
		while (expected_digest.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
